// ----- rtl/windowed_rms_level_meter_assert.svh -----
// ----------------------------------------------------------------------------
// windowed rms level meter assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_RMS_LEVEL_METER_ASSERT_SVH
`define WINDOWED_RMS_LEVEL_METER_ASSERT_SVH

// condition holds at every clock edge out of reset
`define RMSLM_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rms level meter check failed");

// consequent holds in the cycle after the antecedent
`define RMSLM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rms level meter check failed");

`endif

// ----- rtl/rmslm_pkg.sv -----
// ----------------------------------------------------------------------------
// rmslm_pkg
// Widths, register indexes and the bin record shared by the level meter.
// ----------------------------------------------------------------------------
package rmslm_pkg;

    // window sample counter width
    localparam int WINDOW_COUNT_BITS = 16;
    localparam int WIN_CAP           = (1 << WINDOW_COUNT_BITS) - 1;

    // field widths
    localparam int SAMPLE_BITS = 16;
    localparam int SQUARE_BITS = 2 * SAMPLE_BITS;
    localparam int WLEN_BITS   = 16;
    localparam int BIN_BITS    = 12;
    localparam int LEVEL_BITS  = 17;

    // sum of squares and the scaled dividend 36 * sum
    localparam int SUM_BITS  = 47;
    localparam int DVD_BITS  = SUM_BITS + 6;
    localparam int ROOT_BITS = (DVD_BITS + 1) / 2;
    localparam int RAD_BITS  = 2 * ROOT_BITS;
    localparam int STEP_BITS = $clog2(DVD_BITS);

    // level clip at 1.0
    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 17'h10000;

    // bin queue, depth a power of two so pointers wrap on their own
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = WLEN_BITS;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_BINS      = 1'd1;

    localparam logic [WLEN_BITS-1:0] WLEN_RESET = 16'd1;
    localparam logic [BIN_BITS-1:0]  MAXB_RESET = 12'd1200;

    typedef logic [WINDOW_COUNT_BITS-1:0] wcount_t;

    // one finished window handed from front to back
    typedef struct packed {
        logic [SUM_BITS-1:0] sum;
        wcount_t             n;
        logic [BIN_BITS-1:0] idx;
        logic                last;
    } bin_t;

endpackage

// ----- rtl/rmslm_front.sv -----
// ----------------------------------------------------------------------------
// rmslm_front
// Takes samples, squares them, sums each window and queues finished bins.
// ----------------------------------------------------------------------------
module rmslm_front (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    push,
    output logic                                    full,
    input  logic signed [rmslm_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                    start_of_stream,
    input  logic                                    cfg_write,
    input  logic [rmslm_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [rmslm_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic [rmslm_pkg::QCNT_BITS-1:0]         q_count,
    output logic                                    q_push,
    output rmslm_pkg::bin_t                         q_item
);

    logic [rmslm_pkg::WLEN_BITS-1:0]   wlen_reg;
    logic [rmslm_pkg::BIN_BITS-1:0]    maxb_reg;
    logic                              a_valid_reg;
    logic                              a_start_reg;
    logic [rmslm_pkg::SQUARE_BITS-1:0] a_square_reg;
    logic [rmslm_pkg::SUM_BITS-1:0]    sum_reg;
    logic [rmslm_pkg::SUM_BITS-1:0]    sum_next;
    rmslm_pkg::wcount_t                cnt_reg;
    rmslm_pkg::wcount_t                cnt_next;
    logic [rmslm_pkg::BIN_BITS-1:0]    bins_reg;
    logic [rmslm_pkg::BIN_BITS-1:0]    bins_next;

    logic                              accept;
    logic [rmslm_pkg::SAMPLE_BITS-1:0] raw;
    logic [rmslm_pkg::SAMPLE_BITS-1:0] mag;
    logic [rmslm_pkg::SUM_BITS-1:0]    sum_base;
    logic [rmslm_pkg::SUM_BITS-1:0]    sum_add;
    rmslm_pkg::wcount_t                cnt_base;
    rmslm_pkg::wcount_t                cnt_inc;
    rmslm_pkg::wcount_t                n_eff;
    logic [rmslm_pkg::BIN_BITS-1:0]    bins_base;
    logic                              active;
    logic                              win_full;

    // room check counts the item still in the square stage
    assign full   = ({1'b0, q_count} + {{rmslm_pkg::QCNT_BITS{1'b0}}, a_valid_reg})
                    >= (rmslm_pkg::QCNT_BITS + 1)'(rmslm_pkg::QUEUE_DEPTH);
    assign accept = push && !full;

    // magnitude of the sample, -32768 gives 32768
    assign raw = sample;
    assign mag = raw[rmslm_pkg::SAMPLE_BITS-1] ? (~raw + 16'd1) : raw;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= rmslm_pkg::WLEN_RESET;
            maxb_reg <= rmslm_pkg::MAXB_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rmslm_pkg::REG_WINDOW_LENGTH: wlen_reg <= cfg_data;
                rmslm_pkg::REG_MAX_BINS:      maxb_reg <= cfg_data[rmslm_pkg::BIN_BITS-1:0];
                default:                      wlen_reg <= wlen_reg;
            endcase
        end
    end

    // square stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_square_reg <= mag * mag;
            a_start_reg  <= start_of_stream;
        end
    end

    // effective window: zero means one, long windows saturate at the counter
    always_comb
    begin
        if (wlen_reg == '0)
        begin
            n_eff = rmslm_pkg::wcount_t'(1);
        end
        else if (32'(wlen_reg) > rmslm_pkg::WIN_CAP)
        begin
            n_eff = rmslm_pkg::wcount_t'(rmslm_pkg::WIN_CAP);
        end
        else
        begin
            n_eff = rmslm_pkg::wcount_t'(wlen_reg);
        end
    end

    // accumulate stage
    assign sum_base  = a_start_reg ? '0 : sum_reg;
    assign cnt_base  = a_start_reg ? '0 : cnt_reg;
    assign bins_base = a_start_reg ? '0 : bins_reg;
    assign active    = bins_base < maxb_reg;
    assign sum_add   = sum_base + rmslm_pkg::SUM_BITS'(a_square_reg);
    assign cnt_inc   = cnt_base + rmslm_pkg::wcount_t'(1);
    assign win_full  = cnt_inc >= n_eff;

    always_comb
    begin
        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        bins_next = bins_reg;
        q_push    = 1'b0;
        q_item.sum  = sum_add;
        q_item.n    = n_eff;
        q_item.idx  = bins_base;
        q_item.last = ({1'b0, bins_base} + 13'd1) == {1'b0, maxb_reg};
        if (a_valid_reg)
        begin
            sum_next  = sum_base;
            cnt_next  = cnt_base;
            bins_next = bins_base;
            if (active)
            begin
                if (win_full)
                begin
                    q_push    = 1'b1;
                    sum_next  = '0;
                    cnt_next  = '0;
                    bins_next = bins_base + 12'd1;
                end
                else
                begin
                    sum_next = sum_add;
                    cnt_next = cnt_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            cnt_reg  <= '0;
            bins_reg <= '0;
        end
        else
        begin
            sum_reg  <= sum_next;
            cnt_reg  <= cnt_next;
            bins_reg <= bins_next;
        end
    end

endmodule

// ----- rtl/rmslm_fifo.sv -----
// ----------------------------------------------------------------------------
// rmslm_fifo
// Short queue of finished windows between the front and the back.
// ----------------------------------------------------------------------------
module rmslm_fifo (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  rmslm_pkg::bin_t                 wr_item,
    input  logic                            rd_en,
    output rmslm_pkg::bin_t                 rd_item,
    output logic                            q_empty,
    output logic [rmslm_pkg::QCNT_BITS-1:0] q_count
);

    rmslm_pkg::bin_t                 mem_reg [rmslm_pkg::QUEUE_DEPTH];
    logic [rmslm_pkg::QPTR_BITS-1:0] wr_ptr_reg;
    logic [rmslm_pkg::QPTR_BITS-1:0] rd_ptr_reg;
    logic [rmslm_pkg::QCNT_BITS-1:0] count_reg;
    logic                            do_rd;

    assign q_empty = (count_reg == '0);
    assign q_count = count_reg;
    assign rd_item = mem_reg[rd_ptr_reg];
    assign do_rd   = rd_en && !q_empty;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr_en && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/rmslm_calc.sv -----
// ----------------------------------------------------------------------------
// rmslm_calc
// Per-window level: radix-2 divide of 36 * sum by n, digit-by-digit root,
// clip, and the output register.
// ----------------------------------------------------------------------------
module rmslm_calc (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_empty,
    input  rmslm_pkg::bin_t                  q_item,
    output logic                             q_pop,
    input  logic                             pop,
    output logic                             empty,
    output logic [rmslm_pkg::LEVEL_BITS-1:0] level,
    output logic [rmslm_pkg::BIN_BITS-1:0]   bin_index,
    output logic                             final_bin
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_ROOT = 4'b0100,
        ST_DONE = 4'b1000
    } calc_state_t;

    localparam int RB = rmslm_pkg::ROOT_BITS;
    localparam int RW = rmslm_pkg::RAD_BITS;
    localparam int DW = rmslm_pkg::DVD_BITS;
    localparam int WB = rmslm_pkg::WINDOW_COUNT_BITS;

    calc_state_t                         state_reg,  state_next;
    logic [rmslm_pkg::STEP_BITS-1:0]     step_reg,   step_next;
    logic                                out_valid_reg, out_valid_next;
    logic [RW-1:0]                       dq_reg,     dq_next;
    rmslm_pkg::wcount_t                  n_reg,      n_next;
    rmslm_pkg::wcount_t                  drem_reg,   drem_next;
    logic [RB-1:0]                       root_reg,   root_next;
    logic [RB:0]                         srem_reg,   srem_next;
    logic [rmslm_pkg::BIN_BITS-1:0]      idx_reg,    idx_next;
    logic                                fin_reg,    fin_next;
    logic [rmslm_pkg::LEVEL_BITS-1:0]    level_reg,  level_next;
    logic [rmslm_pkg::BIN_BITS-1:0]      oidx_reg,   oidx_next;
    logic                                ofin_reg,   ofin_next;

    logic [DW-1:0]                       dvd;
    logic [WB:0]                         dshift;
    logic [WB:0]                         ddiff;
    logic                                dge;
    logic [RW-1:0]                       dq_shift;
    logic [RB+1:0]                       sshift;
    logic [RB+1:0]                       trial;
    logic [RB+1:0]                       sdiff;
    logic                                sge;

    assign empty     = !out_valid_reg;
    assign level     = level_reg;
    assign bin_index = oidx_reg;
    assign final_bin = ofin_reg;

    // 36 * sum as two shifted adds
    assign dvd = (DW'(q_item.sum) << 5) + (DW'(q_item.sum) << 2);

    // one restoring divide step
    assign dshift   = {drem_reg, dq_reg[DW-1]};
    assign dge      = dshift >= {1'b0, n_reg};
    assign ddiff    = dshift - {1'b0, n_reg};
    assign dq_shift = {dq_reg[RW-2:0], dge};

    // one square root step, two radicand bits at a time
    assign sshift = {srem_reg[RB-1:0], dq_reg[RW-1:RW-2]};
    assign trial  = {root_reg, 2'b01};
    assign sge    = sshift >= trial;
    assign sdiff  = sshift - trial;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        dq_next        = dq_reg;
        n_next         = n_reg;
        drem_next      = drem_reg;
        root_next      = root_reg;
        srem_next      = srem_reg;
        idx_next       = idx_reg;
        fin_next       = fin_reg;
        level_next     = level_reg;
        oidx_next      = oidx_reg;
        ofin_next      = ofin_reg;
        q_pop          = 1'b0;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    dq_next    = {1'b0, dvd};
                    n_next     = q_item.n;
                    idx_next   = q_item.idx;
                    fin_next   = q_item.last;
                    drem_next  = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                drem_next = dge ? rmslm_pkg::wcount_t'(ddiff) : rmslm_pkg::wcount_t'(dshift);
                if (step_reg == rmslm_pkg::STEP_BITS'(DW - 1))
                begin
                    dq_next    = {1'b0, dq_shift[DW-1:0]};
                    step_next  = '0;
                    srem_next  = '0;
                    root_next  = '0;
                    state_next = ST_ROOT;
                end
                else
                begin
                    dq_next   = dq_shift;
                    step_next = step_reg + 1'b1;
                end
            end
            ST_ROOT:
            begin
                srem_next = sge ? sdiff[RB:0] : sshift[RB:0];
                root_next = {root_reg[RB-2:0], sge};
                dq_next   = {dq_reg[RW-3:0], 2'b00};
                if (step_reg == rmslm_pkg::STEP_BITS'(RB - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    if (root_reg > RB'(rmslm_pkg::LEVEL_MAX))
                    begin
                        level_next = rmslm_pkg::LEVEL_MAX;
                    end
                    else
                    begin
                        level_next = root_reg[rmslm_pkg::LEVEL_BITS-1:0];
                    end
                    oidx_next      = idx_reg;
                    ofin_next      = fin_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        dq_reg    <= dq_next;
        n_reg     <= n_next;
        drem_reg  <= drem_next;
        root_reg  <= root_next;
        srem_reg  <= srem_next;
        idx_reg   <= idx_next;
        fin_reg   <= fin_next;
        level_reg <= level_next;
        oidx_reg  <= oidx_next;
        ofin_reg  <= ofin_next;
    end

endmodule

// ----- rtl/windowed_rms_level_meter.sv -----
// ----------------------------------------------------------------------------
// windowed_rms_level_meter
// Sums squared samples per window and reports the clipped, scaled rms level.
// ----------------------------------------------------------------------------
// Input channel: push/full carries one sample and a start flag per item;
// an item is taken when push is high and full is low. Start clears the sum,
// the window count and the bin count before its sample is used.
// Result channel: empty/pop; level, bin_index and final_bin hold the oldest
// result while empty is low, and it is taken when pop is high.
// Configuration: cfg_write with cfg_index 0 sets window_length, 1 sets
// max_bins; write only while the block is idle.
// Throughput: one sample per cycle while full is low. Each full window costs
// the back part 53 divide steps and 27 root steps in a single shared
// divide/root unit, so short windows stall the input once the four-entry bin
// queue fills. A window's last sample passes the square register, the bin
// queue, then the divide, root and done states before its result shows.
// Reset clears all counts and the queue; no clearing pass is needed. While
// the receiver stalls, the result register, then the queue, then the input
// fill up in turn and full rises.
module windowed_rms_level_meter (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     push,
    output logic                                     full,
    input  logic signed [rmslm_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                     start_of_stream,
    output logic                                     empty,
    input  logic                                     pop,
    output logic [rmslm_pkg::LEVEL_BITS-1:0]         level,
    output logic [rmslm_pkg::BIN_BITS-1:0]           bin_index,
    output logic                                     final_bin,
    input  logic                                     cfg_write,
    input  logic [rmslm_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [rmslm_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    logic                            q_push;
    logic                            q_pop;
    logic                            q_empty;
    logic [rmslm_pkg::QCNT_BITS-1:0] q_count;
    rmslm_pkg::bin_t                 q_wr_item;
    rmslm_pkg::bin_t                 q_rd_item;

    // sample intake and window sums
    rmslm_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .sample          (sample),
        .start_of_stream (start_of_stream),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .q_count         (q_count),
        .q_push          (q_push),
        .q_item          (q_wr_item)
    );

    // finished windows waiting for the level unit
    rmslm_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_item (q_wr_item),
        .rd_en   (q_pop),
        .rd_item (q_rd_item),
        .q_empty (q_empty),
        .q_count (q_count)
    );

    // divide, root, clip and result register
    rmslm_calc u_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_item    (q_rd_item),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .level     (level),
        .bin_index (bin_index),
        .final_bin (final_bin)
    );

endmodule

// ----- rtl/rmslm_checker.sv -----
// ----------------------------------------------------------------------------
// rmslm_checker
// Port-level checks on the level meter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "windowed_rms_level_meter_assert.svh"

module rmslm_checker (
    input logic                                     clk,
    input logic                                     rst_n,
    input logic                                     empty,
    input logic                                     pop,
    input logic [rmslm_pkg::LEVEL_BITS-1:0]         level,
    input logic [rmslm_pkg::BIN_BITS-1:0]           bin_index,
    input logic                                     final_bin
);

    // a shown result stays until taken
    `RMSLM_ASSERT_NEXT(a_result_stays, !empty && !pop, !empty)

    // a stalled result keeps its fields
    `RMSLM_ASSERT_NEXT(a_result_holds, !empty && !pop, $stable({level, bin_index, final_bin}))

    // the level never goes past 1.0 after clipping
    `RMSLM_ASSERT_ALWAYS(a_level_clipped, empty || (level <= rmslm_pkg::LEVEL_MAX))

    // bins stop below the largest max_bins, so the top index never shows
    `RMSLM_ASSERT_ALWAYS(a_bin_index_range, empty || (bin_index != 12'hFFF))

endmodule

bind windowed_rms_level_meter rmslm_checker u_checker (.*);
